// ===== hdl/jsu_pkg.sv =====
`timescale 1ns / 1ps

package jsu_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TEXT = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } t_mode;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_BYTE  = 2'd0;
    localparam t_kind KIND_CLOSE = 2'd1;
    localparam t_kind KIND_ERROR = 2'd2;

    localparam int unsigned MAX_RESULTS = 3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Results caused by one input byte; count of zero means none
    typedef struct packed {
        logic [1:0]                   count;
        logic [MAX_RESULTS-1:0][7:0]  data;
        t_kind                        kind;
    } t_group;

endpackage

// ===== hdl/jsu_stream_if.sv =====
`timescale 1ns / 1ps

interface jsu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

// ===== hdl/json_string_unescape.sv =====
`timescale 1ns / 1ps
// A result is registered and presented in the cycle after its input byte transfers.
// Throughput: one byte per cycle while the output is ready and each byte gives at most one result;
// a \u escape that ends in two or three UTF-8 bytes holds input ready low while the single
// output port drains the result group.
// Reset: synchronous, active low; returns to idle awaiting an opening quote.

module json_string_unescape
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    jsu_byte_if.sink    i_in,
    jsu_result_if.source o_out
);

    logic   take;
    logic   free;
    t_group grp;

    assign i_in.ready = free;
    assign take       = i_in.valid && free;

    jsu_decoder u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_in.in_byte),
        .o_grp   (grp)
    );

    jsu_serialiser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_grp   (grp),
        .o_free  (free),
        .o_res   (o_out)
    );

endmodule

// ===== hdl/jsu_decoder.sv =====
`timescale 1ns / 1ps

module jsu_decoder
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    output t_group     o_grp
);

    t_mode       r_mode, n_mode;
    logic [1:0]  r_hex_count, n_hex_count;
    logic [15:0] r_code_point, n_code_point;

    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] cp_next;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hex_val = 4'(i_byte - 8'h30);
        end else if (i_byte >= 8'h61 && i_byte <= 8'h66) begin
            hex_val = 4'(i_byte - 8'h57);
        end else if (i_byte >= 8'h41 && i_byte <= 8'h46) begin
            hex_val = 4'(i_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign cp_next = {r_code_point[11:0], hex_val};

    // Next state
    always_comb begin
        n_mode       = r_mode;
        n_hex_count  = r_hex_count;
        n_code_point = r_code_point;
        unique case (r_mode)
            MODE_IDLE: begin
                if (i_byte == CH_QUOTE) begin
                    n_mode = MODE_TEXT;
                end
            end
            MODE_TEXT: begin
                if (i_byte == CH_NUL || i_byte == CH_QUOTE) begin
                    n_mode = MODE_IDLE;
                end else if (i_byte == CH_BSL) begin
                    n_mode = MODE_ESC;
                end
            end
            MODE_ESC: begin
                case (i_byte) inside
                    CH_U: begin
                        n_mode       = MODE_HEX;
                        n_hex_count  = 2'd0;
                        n_code_point = 16'd0;
                    end
                    CH_N, CH_T, CH_R, CH_B, CH_F, CH_BSL, CH_QUOTE, CH_SLASH: begin
                        n_mode = MODE_TEXT;
                    end
                    default: begin
                        n_mode       = MODE_IDLE;
                        n_hex_count  = 2'd0;
                        n_code_point = 16'd0;
                    end
                endcase
            end
            MODE_HEX: begin
                if (!hex_ok) begin
                    n_mode       = MODE_IDLE;
                    n_hex_count  = 2'd0;
                    n_code_point = 16'd0;
                end else begin
                    n_code_point = cp_next;
                    n_hex_count  = r_hex_count + 2'd1;
                    if (r_hex_count == 2'd3) begin
                        n_mode = MODE_TEXT;
                    end
                end
            end
            default: n_mode = MODE_IDLE;
        endcase
    end

    // Results
    always_comb begin
        o_grp       = '0;
        o_grp.kind  = KIND_BYTE;
        unique case (r_mode)
            MODE_IDLE: begin
                if (i_byte != CH_QUOTE) begin
                    o_grp.count = 2'd1;
                    o_grp.kind  = KIND_ERROR;
                end
            end
            MODE_TEXT: begin
                if (i_byte == CH_NUL) begin
                    o_grp.count = 2'd1;
                    o_grp.kind  = KIND_ERROR;
                end else if (i_byte == CH_QUOTE) begin
                    o_grp.count = 2'd1;
                    o_grp.kind  = KIND_CLOSE;
                end else if (i_byte != CH_BSL) begin
                    o_grp.count   = 2'd1;
                    o_grp.data[0] = i_byte;
                end
            end
            MODE_ESC: begin
                o_grp.count = 2'd1;
                case (i_byte) inside
                    CH_U:                      o_grp.count   = 2'd0;
                    CH_N:                      o_grp.data[0] = 8'h0A;
                    CH_T:                      o_grp.data[0] = 8'h09;
                    CH_R:                      o_grp.data[0] = 8'h0D;
                    CH_B:                      o_grp.data[0] = 8'h08;
                    CH_F:                      o_grp.data[0] = 8'h0C;
                    CH_BSL, CH_QUOTE, CH_SLASH: o_grp.data[0] = i_byte;
                    default:                   o_grp.kind    = KIND_ERROR;
                endcase
            end
            MODE_HEX: begin
                if (!hex_ok) begin
                    o_grp.count = 2'd1;
                    o_grp.kind  = KIND_ERROR;
                end else if (r_hex_count == 2'd3) begin
                    // UTF-8: one, two or three bytes by code point range
                    if (cp_next[15:7] == 9'd0) begin
                        o_grp.count   = 2'd1;
                        o_grp.data[0] = {1'b0, cp_next[6:0]};
                    end else if (cp_next[15:11] == 5'd0) begin
                        o_grp.count   = 2'd2;
                        o_grp.data[0] = {3'b110, cp_next[10:6]};
                        o_grp.data[1] = {2'b10, cp_next[5:0]};
                    end else begin
                        o_grp.count   = 2'd3;
                        o_grp.data[0] = {4'b1110, cp_next[15:12]};
                        o_grp.data[1] = {2'b10, cp_next[11:6]};
                        o_grp.data[2] = {2'b10, cp_next[5:0]};
                    end
                end
            end
            default: o_grp.count = 2'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_hex_count  <= 2'd0;
            r_code_point <= 16'd0;
        end else if (i_take) begin
            r_mode       <= n_mode;
            r_hex_count  <= n_hex_count;
            r_code_point <= n_code_point;
        end
    end

endmodule

// ===== hdl/jsu_serialiser.sv =====
`timescale 1ns / 1ps

module jsu_serialiser
    import jsu_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_group        i_grp,
    output logic          o_free,
    jsu_result_if.source  o_res
);

    logic       r_valid;
    logic [1:0] r_idx;
    t_group     r_grp;

    logic       at_last;
    logic       done;

    assign at_last = (r_idx == r_grp.count - 2'd1);
    assign done    = r_valid && o_res.ready && at_last;
    assign o_free  = !r_valid || done;

    assign o_res.valid    = r_valid;
    assign o_res.out_byte = r_grp.data[r_idx];
    assign o_res.kind     = r_grp.kind;
    assign o_res.last     = at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load && i_grp.count != 2'd0) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (done) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (r_valid && o_res.ready) begin
            // advance to the next byte of the group
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_grp.count != 2'd0) begin
            r_grp <= i_grp;
        end
    end

endmodule

// ===== bench/jsu_decode_check.sv =====
`timescale 1ns / 1ps

module jsu_decode_check
    import jsu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    jsu_byte_if   i_bytes,
    jsu_result_if i_results,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_result;

    t_result     decoded_q[$];
    t_mode       mode       = MODE_IDLE;
    logic [1:0]  hex_seen   = 2'd0;
    logic [15:0] code_point = 16'h0000;
    int          n_fail     = 0;

    // Bit 4 set flags a byte that is not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b0, c[3:0] + 4'd9};
        return 5'h10;
    endfunction

    task automatic push_result(input logic [7:0] d, input t_kind k, input logic l);
        decoded_q.push_back(t_result'{data: d, kind: k, last: l});
    endtask

    task automatic flag_malformed();
        mode       = MODE_IDLE;
        hex_seen   = 2'd0;
        code_point = 16'h0000;
        push_result(8'h00, KIND_ERROR, 1'b1);
    endtask

    task automatic push_utf8(input logic [15:0] v);
        if (v <= 16'h007F) begin
            push_result(v[7:0], KIND_BYTE, 1'b1);
        end else if (v <= 16'h07FF) begin
            push_result({3'b110, v[10:6]}, KIND_BYTE, 1'b0);
            push_result({2'b10, v[5:0]}, KIND_BYTE, 1'b1);
        end else begin
            // surrogate halves land here too, each encoded on its own
            push_result({4'b1110, v[15:12]}, KIND_BYTE, 1'b0);
            push_result({2'b10, v[11:6]}, KIND_BYTE, 1'b0);
            push_result({2'b10, v[5:0]}, KIND_BYTE, 1'b1);
        end
    endtask

    task automatic predict_byte(input logic [7:0] c);
        logic [4:0] nib;
        logic [7:0] esc;
        logic       esc_ok;
        case (mode)
            MODE_IDLE: begin
                if (c == CH_QUOTE) mode = MODE_TEXT;
                else flag_malformed();
            end
            MODE_TEXT: begin
                if (c == CH_NUL) begin
                    flag_malformed();
                end else if (c == CH_QUOTE) begin
                    mode = MODE_IDLE;
                    push_result(8'h00, KIND_CLOSE, 1'b1);
                end else if (c == CH_BSL) begin
                    mode = MODE_ESC;
                end else begin
                    push_result(c, KIND_BYTE, 1'b1);
                end
            end
            MODE_ESC: begin
                esc_ok = 1'b1;
                esc    = c;
                case (c)
                    CH_N: esc = 8'h0A;
                    CH_T: esc = 8'h09;
                    CH_R: esc = 8'h0D;
                    CH_B: esc = 8'h08;
                    CH_F: esc = 8'h0C;
                    CH_BSL, CH_QUOTE, CH_SLASH, CH_U: esc = c;
                    default: esc_ok = 1'b0;
                endcase
                if (c == CH_U) begin
                    mode       = MODE_HEX;
                    hex_seen   = 2'd0;
                    code_point = 16'h0000;
                end else if (esc_ok) begin
                    mode = MODE_TEXT;
                    push_result(esc, KIND_BYTE, 1'b1);
                end else begin
                    flag_malformed();
                end
            end
            default: begin
                nib = hex_nibble(c);
                if (nib[4]) begin
                    flag_malformed();
                end else begin
                    code_point = {code_point[11:0], nib[3:0]};
                    if (hex_seen == 2'd3) begin
                        mode     = MODE_TEXT;
                        hex_seen = 2'd0;
                        push_utf8(code_point);
                    end else begin
                        hex_seen = hex_seen + 2'd1;
                    end
                end
            end
        endcase
    endtask

    task automatic record_failure(input string msg);
        n_fail++;
        if (n_fail <= 10) $display("%0t: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            mode       = MODE_IDLE;
            hex_seen   = 2'd0;
            code_point = 16'h0000;
            decoded_q.delete();
        end else begin
            // predict before popping so a same-edge result still finds its entry
            if (i_bytes.valid && i_bytes.ready) predict_byte(i_bytes.in_byte);
            if (i_results.valid && i_results.ready) begin
                got = t_result'{data: i_results.out_byte, kind: i_results.kind,
                                last: i_results.last};
                if (decoded_q.size() == 0) begin
                    record_failure($sformatf("unexpected result: byte %02h kind %0d last %0d",
                                             got.data, got.kind, got.last));
                end else begin
                    want = decoded_q.pop_front();
                    if (got.data !== want.data || got.kind !== want.kind
                            || got.last !== want.last) begin
                        record_failure($sformatf(
                            "mismatch: want byte %02h kind %0d last %0d, got %02h %0d %0d",
                            want.data, want.kind, want.last, got.data, got.kind, got.last));
                    end
                end
            end
        end
        o_fail_count <= n_fail;
        o_pending    <= decoded_q.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import jsu_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [7:0] SIMPLE_ESC [8] = '{CH_N, CH_T, CH_R, CH_B, CH_F,
                                              CH_BSL, CH_QUOTE, CH_SLASH};

    typedef enum int {
        FAULT_NONE,
        FAULT_NOISE,
        FAULT_BAD_ESCAPE,
        FAULT_BAD_HEX,
        FAULT_EOT_TEXT,
        FAULT_EOT_ESCAPE,
        FAULT_EOT_HEX
    } t_fault;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   n_sent;
    int   stall_cycles = 0;
    int   fail_count;
    int   pending;

    jsu_byte_if   byte_ch ();
    jsu_result_if result_ch ();

    json_string_unescape uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (result_ch)
    );

    jsu_decode_check decode_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_bytes      (byte_ch),
        .i_results    (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        n_sent++;
    endtask

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        if (nib < 4'd10) return "0" + nib;
        return ($urandom_range(1) ? "A" : "a") + nib - 8'd10;
    endfunction

    function automatic logic [15:0] pick_code_point();
        logic [15:0] bounds [6] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
        case ($urandom_range(4))
            0: return 16'($urandom_range(16'h007F));
            1: return 16'($urandom_range(16'h07FF, 16'h0080));
            2: return 16'($urandom_range(16'hDFFF, 16'hD800));
            3: return bounds[$urandom_range(5)];
            default: return 16'($urandom);
        endcase
    endfunction

    // Send backslash-u and the top n_digits nibbles of v
    task automatic send_u_escape(input logic [15:0] v, input int n_digits);
        send_byte(CH_BSL);
        send_byte(CH_U);
        for (int k = 0; k < n_digits; k++) send_byte(hex_digit(v[15 - 4*k -: 4]));
    endtask

    task automatic send_part();
        logic [7:0] b;
        case ($urandom_range(3))
            0: send_u_escape(pick_code_point(), 4);
            1: begin
                send_byte(CH_BSL);
                send_byte(SIMPLE_ESC[$urandom_range(7)]);
            end
            default: begin
                do b = 8'($urandom_range(255, 1)); while (b == CH_QUOTE || b == CH_BSL);
                send_byte(b);
            end
        endcase
    endtask

    task automatic send_string();
        t_fault     fault;
        logic [7:0] b;
        int         n_parts;
        n_parts = $urandom_range(8);
        fault   = FAULT_NONE;
        if ($urandom_range(99) < 20) fault = t_fault'($urandom_range(FAULT_EOT_HEX, FAULT_NOISE));
        if (fault == FAULT_NOISE) begin
            repeat ($urandom_range(3, 1)) begin
                do b = 8'($urandom); while (b == CH_QUOTE);
                send_byte(b);
            end
        end
        send_byte(CH_QUOTE);
        repeat (n_parts) send_part();
        case (fault)
            FAULT_BAD_ESCAPE: begin
                do b = 8'($urandom);
                while (b inside {CH_N, CH_T, CH_R, CH_B, CH_F, CH_BSL, CH_QUOTE, CH_SLASH, CH_U});
                send_byte(CH_BSL);
                send_byte(b);
            end
            FAULT_BAD_HEX: begin
                if ($urandom_range(3) == 0) b = CH_QUOTE;
                else do b = 8'($urandom); while (b inside {["0":"9"], ["a":"f"], ["A":"F"]});
                send_u_escape(pick_code_point(), $urandom_range(3));
                send_byte(b);
            end
            FAULT_EOT_TEXT: send_byte(CH_NUL);
            FAULT_EOT_ESCAPE: begin
                send_byte(CH_BSL);
                send_byte(CH_NUL);
            end
            FAULT_EOT_HEX: begin
                send_u_escape(pick_code_point(), $urandom_range(3));
                send_byte(CH_NUL);
            end
            default: send_byte(CH_QUOTE);
        endcase
    endtask

    // Hold the sender until every predicted result has come back
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        logic [7:0] opening [26];
        opening = '{8'h41, CH_NUL, CH_QUOTE, 8'hFF,
                    CH_BSL, CH_U, "F", "f", "f", "F",
                    CH_BSL, "q",
                    CH_QUOTE, CH_BSL, CH_U, "0", "0", CH_NUL,
                    CH_QUOTE, CH_BSL, CH_U, "0", "0", "0", "0", CH_QUOTE};
        rst_n           <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.in_byte <= 8'h00;
        recv_idle_pct   <= 77;
        send_idle_pct   = 37;
        n_sent          = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening[k]) send_byte(opening[k]);
        while (n_sent < 90) send_string();
        wait_drained();

        send_idle_pct = 77;
        recv_idle_pct <= 37;
        while (n_sent < 150) send_string();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        while (n_sent < 210) send_string();
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== json_string_unescape.f =====
hdl/jsu_pkg.sv
hdl/jsu_stream_if.sv
hdl/jsu_decoder.sv
hdl/jsu_serialiser.sv
hdl/json_string_unescape.sv
bench/jsu_decode_check.sv
bench/tb.sv
